FILE: rtl/psf_pkg.sv
package psf_pkg;

  localparam int COORD_W = 32;
  localparam int ACC_W   = 48;
  localparam int WGT_W   = 16;
  localparam int STEP_W  = 6;
  localparam int MAX_STEPS = 32;

  localparam logic [3:0] FUNC_LAST_LINE  = 4'd7;
  localparam logic [3:0] FUNC_LAST_CURVE = 4'd11;
  localparam logic [3:0] FUNC_LAST_HORIZ = 4'd5;
  localparam logic [3:0] FUNC_LAST_PLAIN = 4'd3;
  localparam logic [3:0] FUNC_LAST_CUBIC = 4'd9;

  typedef enum logic [1:0] {
    TERM_P0 = 2'd0,
    TERM_P1 = 2'd1,
    TERM_P2 = 2'd2,
    TERM_P3 = 2'd3
  } term_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LINE,
    ST_CLR,
    ST_WGT,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_DWAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic acc_clr;
    logic wgt_ld;
    logic mul;
    logic acc_add;
    logic div_start;
    logic emit_line;
    logic emit_pt;
  } cmd_t;

  typedef struct packed {
    logic is_line;
    logic is_curve;
    logic out_free;
    logic div_done;
    logic term_last;
    logic pt_last;
  } sts_t;

  function automatic logic signed [COORD_W-1:0] sat_add(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W:0] sum;
    sum = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (sum[COORD_W] != sum[COORD_W-1]) begin
      return sum[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return sum[COORD_W-1:0];
  endfunction

  function automatic logic [STEP_W-1:0] clamp_steps(input logic [STEP_W-1:0] r);
    if (r == '0) begin
      return STEP_W'(1);
    end
    if (r > STEP_W'(MAX_STEPS)) begin
      return STEP_W'(MAX_STEPS);
    end
    return r;
  endfunction

  function automatic logic [WGT_W-1:0] weight(
    input logic              cubic,
    input term_t             j,
    input logic [STEP_W-1:0] s,
    input logic [STEP_W-1:0] k
  );
    logic [17:0] ss;
    logic [17:0] kk;
    logic [17:0] w;
    ss = 18'(s) * 18'(s);
    kk = 18'(k) * 18'(k);
    w = '0;
    if (cubic) begin
      unique case (j)
        TERM_P0: w = ss * 18'(s);
        TERM_P1: w = 18'(3) * ss * 18'(k);
        TERM_P2: w = 18'(3) * kk * 18'(s);
        TERM_P3: w = kk * 18'(k);
        default: w = '0;
      endcase
    end else begin
      unique case (j)
        TERM_P0: w = ss;
        TERM_P1: w = 18'(2) * 18'(s) * 18'(k);
        TERM_P2: w = kk;
        TERM_P3: w = '0;
        default: w = '0;
      endcase
    end
    return w[WGT_W-1:0];
  endfunction

endpackage

FILE: rtl/psf_div.sv
module psf_div
  import psf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [ACC_W-1:0]   num,
  input  logic        [WGT_W-1:0]   den,
  output logic                      done,
  output logic signed [COORD_W-1:0] quo
);

  localparam logic signed [ACC_W-1:0] Q_HI =
    {{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] Q_LO =
    {{(ACC_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  logic             busy;
  logic [5:0]       cnt;
  logic [WGT_W-1:0] rem;
  logic [ACC_W-1:0] dq;
  logic             neg;

  logic [ACC_W-1:0] mag;
  logic [WGT_W:0]   trial;
  logic [WGT_W:0]   diff;
  logic             ge;
  logic signed [ACC_W-1:0] sq;

  assign mag   = (num[ACC_W-1] ? -num : num) + ACC_W'(den >> 1);
  assign trial = {rem, dq[ACC_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};
  assign sq    = neg ? -dq : dq;

  always_comb begin
    if (sq > Q_HI) begin
      quo = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (sq < Q_LO) begin
      quo = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      quo = sq[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        neg  <= num[ACC_W-1];
        dq   <= mag;
      end else if (busy) begin
        rem <= ge ? diff[WGT_W-1:0] : trial[WGT_W-1:0];
        dq  <= {dq[ACC_W-2:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(ACC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst) busy |-> !start)
    else $error("divider restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  a_done_after: assert property (@(posedge clk) disable iff (rst) $rose(done) |-> $past(busy))
    else $error("divider done without iterating");

endmodule

FILE: rtl/psf_ctrl.sv
module psf_ctrl
  import psf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.is_line) begin
            state_next = ST_LINE;
          end else if (sts.is_curve) begin
            state_next = ST_CLR;
          end
        end
      end
      ST_LINE: begin
        if (sts.out_free) begin
          cmd.emit_line = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_CLR: begin
        cmd.acc_clr = 1'b1;
        state_next = ST_WGT;
      end
      ST_WGT: begin
        cmd.wgt_ld = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_add = 1'b1;
        state_next = sts.term_last ? ST_DIV : ST_WGT;
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        state_next = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (sts.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_pt = 1'b1;
          state_next = sts.pt_last ? ST_IDLE : ST_CLR;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/psf_datapath.sv
module psf_datapath
  import psf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  input  logic        [3:0]         func,
  input  logic signed [COORD_W-1:0] ax,
  input  logic signed [COORD_W-1:0] ay,
  input  logic signed [COORD_W-1:0] bx,
  input  logic signed [COORD_W-1:0] by,
  input  logic signed [COORD_W-1:0] cx,
  input  logic signed [COORD_W-1:0] cy,
  input  logic        [STEP_W-1:0]  cubic_steps,
  input  logic        [STEP_W-1:0]  quad_steps,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] px,
  output logic signed [COORD_W-1:0] py,
  output logic                      last
);

  logic signed [COORD_W-1:0] pen_x;
  logic signed [COORD_W-1:0] pen_y;
  logic signed [COORD_W-1:0] cpx [4];
  logic signed [COORD_W-1:0] cpy [4];
  logic                      cubic;
  logic [STEP_W-1:0]         n;
  logic [STEP_W-1:0]         k;
  logic [WGT_W-1:0]          d;
  term_t                     j;
  logic [WGT_W-1:0]          wgt;
  logic signed [ACC_W-1:0]   prod_x;
  logic signed [ACC_W-1:0]   prod_y;
  logic signed [ACC_W-1:0]   acc_x;
  logic signed [ACC_W-1:0]   acc_y;

  logic                      rel;
  logic signed [COORD_W-1:0] ra_x, ra_y, rb_x, rb_y, rc_x, rc_y;
  logic [STEP_W-1:0]         n_new;
  logic [17:0]               nn;
  logic signed [ACC_W:0]     mx;
  logic signed [ACC_W:0]     my;
  logic                      done_x, done_y;
  logic signed [COORD_W-1:0] q_x, q_y;
  logic                      out_free;

  assign rel  = func[0];
  assign ra_x = rel ? sat_add(pen_x, ax) : ax;
  assign ra_y = rel ? sat_add(pen_y, ay) : ay;
  assign rb_x = rel ? sat_add(pen_x, bx) : bx;
  assign rb_y = rel ? sat_add(pen_y, by) : by;
  assign rc_x = rel ? sat_add(pen_x, cx) : cx;
  assign rc_y = rel ? sat_add(pen_y, cy) : cy;
  assign n_new = clamp_steps(func <= FUNC_LAST_CUBIC ? cubic_steps : quad_steps);
  assign nn = 18'(n_new) * 18'(n_new);

  assign mx = cpx[j] * $signed({1'b0, wgt});
  assign my = cpy[j] * $signed({1'b0, wgt});

  assign out_free = !out_valid || !out_stall;

  assign sts.is_line   = func <= FUNC_LAST_LINE;
  assign sts.is_curve  = func > FUNC_LAST_LINE && func <= FUNC_LAST_CURVE;
  assign sts.out_free  = out_free;
  assign sts.div_done  = done_x;
  assign sts.term_last = j == TERM_P3;
  assign sts.pt_last   = k == n;

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x <= '0;
      pen_y <= '0;
    end else if (cmd.load) begin
      if (func <= FUNC_LAST_PLAIN) begin
        pen_x <= ra_x;
        pen_y <= ra_y;
      end else if (func <= FUNC_LAST_HORIZ) begin
        pen_x <= ra_x;
      end else if (func <= FUNC_LAST_LINE) begin
        pen_y <= rel ? sat_add(pen_y, ax) : ax;
      end else if (func <= FUNC_LAST_CUBIC) begin
        pen_x <= rc_x;
        pen_y <= rc_y;
      end else if (func <= FUNC_LAST_CURVE) begin
        pen_x <= rb_x;
        pen_y <= rb_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cpx[0] <= pen_x;
      cpy[0] <= pen_y;
      cpx[1] <= ra_x;
      cpy[1] <= ra_y;
      cpx[2] <= rb_x;
      cpy[2] <= rb_y;
      cpx[3] <= rc_x;
      cpy[3] <= rc_y;
      cubic  <= func <= FUNC_LAST_CUBIC;
      n      <= n_new;
      k      <= STEP_W'(1);
      d      <= (func <= FUNC_LAST_CUBIC) ? WGT_W'(nn * 18'(n_new)) : WGT_W'(nn);
    end
    if (cmd.acc_clr) begin
      acc_x <= '0;
      acc_y <= '0;
      j     <= TERM_P0;
    end
    if (cmd.wgt_ld) begin
      wgt <= weight(cubic, j, n - k, k);
    end
    if (cmd.mul) begin
      prod_x <= mx[ACC_W-1:0];
      prod_y <= my[ACC_W-1:0];
    end
    if (cmd.acc_add) begin
      acc_x <= acc_x + prod_x;
      acc_y <= acc_y + prod_y;
      j     <= term_t'(j + 2'd1);
    end
    if (cmd.emit_pt) begin
      k <= k + STEP_W'(1);
    end
  end

  psf_div u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (acc_x),
    .den   (d),
    .done  (done_x),
    .quo   (q_x)
  );

  psf_div u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (acc_y),
    .den   (d),
    .done  (done_y),
    .quo   (q_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_line || cmd.emit_pt) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_line) begin
      px   <= pen_x;
      py   <= pen_y;
      last <= 1'b1;
    end else if (cmd.emit_pt) begin
      px   <= q_x;
      py   <= q_y;
      last <= k == n;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
      (cmd.emit_pt || cmd.emit_line) |-> out_free)
    else $error("beat written over an untaken beat");
  a_k_range: assert property (@(posedge clk) disable iff (rst)
      cmd.emit_pt |-> (k >= STEP_W'(1) && k <= n))
    else $error("point index out of range");
  a_div_pair: assert property (@(posedge clk) disable iff (rst) done_x == done_y)
    else $error("dividers out of step");

endmodule

FILE: rtl/path_segment_flattener_unit.sv
// Path segment flattener. Each input beat carries one path segment; move, line,
// horizontal and vertical segments produce one output beat: the pen register is
// loaded on acceptance and the beat is registered out once the output is free,
// while a cubic or quadratic curve produces one beat per step (cubic_steps or
// quad_steps, clamped to 1..32) with last set on the end point. Each curve point
// waits for the bit-serial dividers that normalize the weighted sum, and a curve
// holds the input until its last point is emitted. Close and unused codes are
// taken with no output. Coordinates are signed Q16.16 and results saturate.
module path_segment_flattener_unit
  import psf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [3:0]                func,
  input  logic signed [COORD_W-1:0] ax,
  input  logic signed [COORD_W-1:0] ay,
  input  logic signed [COORD_W-1:0] bx,
  input  logic signed [COORD_W-1:0] by,
  input  logic signed [COORD_W-1:0] cx,
  input  logic signed [COORD_W-1:0] cy,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] px,
  output logic signed [COORD_W-1:0] py,
  output logic                      last
);

  logic [STEP_W-1:0] cubic_steps;
  logic [STEP_W-1:0] quad_steps;
  cmd_t              cmd;
  sts_t              sts;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'(quad_steps) : 32'(cubic_steps);

  always_ff @(posedge clk) begin
    if (rst) begin
      cubic_steps <= STEP_W'(10);
      quad_steps  <= STEP_W'(6);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        quad_steps <= pwdata[STEP_W-1:0];
      end else begin
        cubic_steps <= pwdata[STEP_W-1:0];
      end
    end
  end

  psf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  psf_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .func        (func),
    .ax          (ax),
    .ay          (ay),
    .bx          (bx),
    .by          (by),
    .cx          (cx),
    .cy          (cy),
    .cubic_steps (cubic_steps),
    .quad_steps  (quad_steps),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .px          (px),
    .py          (py),
    .last        (last)
  );

endmodule

FILE: tb/tb_path_segment_flattener_unit.sv
module tb_path_segment_flattener_unit;
  import psf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 5000000;
  localparam logic [3:0] F_MOVE_ABS  = 4'd0;
  localparam logic [3:0] F_MOVE_REL  = 4'd1;
  localparam logic [3:0] F_LINE_ABS  = 4'd2;
  localparam logic [3:0] F_LINE_REL  = 4'd3;
  localparam logic [3:0] F_HORIZ_ABS = 4'd4;
  localparam logic [3:0] F_HORIZ_REL = 4'd5;
  localparam logic [3:0] F_VERT_ABS  = 4'd6;
  localparam logic [3:0] F_VERT_REL  = 4'd7;
  localparam logic [3:0] F_CUBIC_ABS = 4'd8;
  localparam logic [3:0] F_CUBIC_REL = 4'd9;
  localparam logic [3:0] F_QUAD_ABS  = 4'd10;
  localparam logic [3:0] F_QUAD_REL  = 4'd11;
  localparam logic [3:0] F_CLOSE     = 4'd12;
  localparam logic [2:0] REG_CUBIC_STEPS = 3'd0;
  localparam logic [2:0] REG_QUAD_STEPS  = 3'd4;
  localparam logic signed [31:0] C_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] C_MIN = 32'sh80000000;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      fin;
  } point_t;

  class flatten_scoreboard;
    point_t    pending[$];
    longint    pen_x;
    longint    pen_y;
    bit [5:0]  cubic_n;
    bit [5:0]  quad_n;
    int        errors;

    function new();
      pen_x = 0;
      pen_y = 0;
      cubic_n = 6'd10;
      quad_n = 6'd6;
      errors = 0;
    endfunction

    function longint clip(longint v);
      if (v > longint'(C_MAX)) return longint'(C_MAX);
      if (v < longint'(C_MIN)) return longint'(C_MIN);
      return v;
    endfunction

    function longint div_near(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
    endfunction

    function longint step_count(bit [5:0] r);
      if (r == 0) return 1;
      if (r > MAX_STEPS) return MAX_STEPS;
      return r;
    endfunction

    function void set_reg(logic [2:0] addr, logic [31:0] val);
      if (addr == REG_CUBIC_STEPS) cubic_n = val[5:0];
      else if (addr == REG_QUAD_STEPS) quad_n = val[5:0];
    endfunction

    function void push(longint x, longint y, bit fin);
      point_t p;
      p.x = x[31:0];
      p.y = y[31:0];
      p.fin = fin;
      pending = {pending, p};
    endfunction

    function void note_segment(logic [3:0] f, logic signed [31:0] ia, logic signed [31:0] ib,
                               logic signed [31:0] ic, logic signed [31:0] id,
                               logic signed [31:0] ie, logic signed [31:0] ig);
      longint x0, y0, a, b, c, d, e, g, n, s, w0, w1, w2, w3, den;
      bit rel;
      x0 = pen_x;
      y0 = pen_y;
      rel = f[0];
      a = ia; b = ib; c = ic; d = id; e = ie; g = ig;
      if (f > F_QUAD_REL) return;
      if (f <= F_VERT_REL) begin
        if (f <= F_LINE_REL) begin
          pen_x = rel ? clip(x0 + a) : a;
          pen_y = rel ? clip(y0 + b) : b;
        end else if (f <= F_HORIZ_REL) begin
          pen_x = rel ? clip(x0 + a) : a;
        end else begin
          pen_y = rel ? clip(y0 + a) : a;
        end
        push(pen_x, pen_y, 1'b1);
        return;
      end
      if (rel) begin
        a = clip(x0 + a); b = clip(y0 + b);
        c = clip(x0 + c); d = clip(y0 + d);
        e = clip(x0 + e); g = clip(y0 + g);
      end
      if (f <= F_CUBIC_REL) begin
        n = step_count(cubic_n);
        den = n * n * n;
        for (longint k = 1; k <= n; k++) begin
          s = n - k;
          w0 = s * s * s; w1 = 3 * s * s * k; w2 = 3 * s * k * k; w3 = k * k * k;
          push(clip(div_near(x0 * w0 + a * w1 + c * w2 + e * w3, den)),
               clip(div_near(y0 * w0 + b * w1 + d * w2 + g * w3, den)), k == n);
        end
        pen_x = e;
        pen_y = g;
      end else begin
        n = step_count(quad_n);
        den = n * n;
        for (longint k = 1; k <= n; k++) begin
          s = n - k;
          w0 = s * s; w1 = 2 * s * k; w2 = k * k;
          push(clip(div_near(x0 * w0 + a * w1 + c * w2, den)),
               clip(div_near(y0 * w0 + b * w1 + d * w2, den)), k == n);
        end
        pen_x = c;
        pen_y = d;
      end
    endfunction

    function void check_point(logic signed [31:0] x, logic signed [31:0] y, logic fin);
      point_t p;
      if (pending.size() == 0) begin
        $display("%0t: unexpected point x=%h y=%h last=%b", $time, x, y, fin);
        errors++;
        return;
      end
      p = pending.pop_front();
      if (x !== p.x) begin
        $display("%0t: px expected %h actual %h", $time, p.x, x);
        errors++;
      end
      if (y !== p.y) begin
        $display("%0t: py expected %h actual %h", $time, p.y, y);
        errors++;
      end
      if (fin !== p.fin) begin
        $display("%0t: last expected %b actual %b", $time, p.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_stall;
  logic [3:0] func;
  logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy;
  logic out_valid, out_stall;
  logic signed [COORD_W-1:0] px, py;
  logic last;

  flatten_scoreboard sb;
  int cycles;
  int points_seen;
  bit calm;
  int hold_at;

  path_segment_flattener_unit i_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .func, .ax, .ay, .bx, .by, .cx, .cy,
    .out_valid, .out_stall, .px, .py, .last
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_path_segment_flattener_unit failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_point(px, py, last);
      points_seen++;
    end
  end

  initial begin
    int idle_left, hold_left;
    idle_left = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_at >= 0 && points_seen >= hold_at) begin
        hold_left = 600;
        hold_at = -1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else if (calm) begin
        out_stall = 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        out_stall = 1'b1;
      end else if ($urandom_range(5) == 0) begin
        idle_left = $urandom_range(11);
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(7))
      0, 1, 2, 3: return $urandom;
      4, 5: return $signed($urandom_range(2097152)) - 32'sd1048576;
      6: return C_MAX;
      default: return C_MIN;
    endcase
  endfunction

  task automatic apb_write(logic [2:0] addr, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(addr, val);
    @(negedge clk);
    if (prdata !== {26'd0, val[5:0]}) begin
      $display("%0t: prdata expected %h actual %h", $time, {26'd0, val[5:0]}, prdata);
      sb.errors++;
    end
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0 || in_stall) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic send_segment(logic [3:0] f, logic signed [31:0] a, logic signed [31:0] b,
                              logic signed [31:0] c, logic signed [31:0] d,
                              logic signed [31:0] e, logic signed [31:0] g);
    if (!calm && $urandom_range(4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(12, 1)) @(negedge clk);
    end
    in_valid = 1'b1;
    func = f; ax = a; ay = b; bx = c; by = d; cx = e; cy = g;
    do @(posedge clk); while (in_stall);
    sb.note_segment(f, a, b, c, d, e, g);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [3:0] f;
    if ($urandom_range(9) == 0) f = 4'(12 + $urandom_range(3));
    else f = 4'($urandom_range(11));
    send_segment(f, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                 pick_coord(), pick_coord());
  endtask

  initial begin
    logic [31:0] cub_cfg[7] = '{1, 32, 0, 63, 5, 2, 3};
    logic [31:0] quad_cfg[7] = '{1, 32, 0, 45, 3, 4, 7};
    sb = new();
    cycles = 0;
    points_seen = 0;
    calm = 1'b0;
    hold_at = 5;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0;
    func = F_CLOSE; ax = '0; ay = '0; bx = '0; by = '0; cx = '0; cy = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_segment(F_MOVE_ABS, C_MAX, C_MIN, 0, 0, 0, 0);
    send_segment(F_MOVE_REL, C_MAX, C_MIN, -1, 1, 7, 7);
    send_segment(F_LINE_ABS, C_MIN, C_MAX, 5, 5, 5, 5);
    send_segment(F_LINE_REL, C_MIN, C_MAX, 0, 0, 0, 0);
    send_segment(F_HORIZ_ABS, 32'sh00010000, 9, 9, 9, 9, 9);
    send_segment(F_HORIZ_REL, C_MAX, 0, 0, 0, 0, 0);
    send_segment(F_VERT_ABS, -32'sh00020000, 3, 3, 3, 3, 3);
    send_segment(F_VERT_REL, C_MIN, 0, 0, 0, 0, 0);
    send_segment(F_CUBIC_ABS, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN);
    send_segment(F_CUBIC_REL, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX);
    send_segment(F_QUAD_ABS, C_MIN, C_MAX, C_MAX, C_MIN, 1, 1);
    send_segment(F_QUAD_REL, C_MAX, C_MAX, C_MIN, C_MIN, 2, 2);
    send_segment(F_CLOSE, 1, 2, 3, 4, 5, 6);
    send_segment(4'd13, 0, 0, 0, 0, 0, 0);
    send_segment(4'd14, 0, 0, 0, 0, 0, 0);
    send_segment(4'd15, -1, -1, -1, -1, -1, -1);
    send_segment(F_LINE_ABS, 32'sh00030000, 32'sh00040000, 0, 0, 0, 0);
    send_segment(F_CUBIC_REL, 32'sh00010000, -32'sh00010000, 32'sh00050000, 1, 3, -7);
    send_segment(F_QUAD_REL, -32'sh00008000, 32'sh00018000, 32'sh00002000, -5, 0, 0);
    send_segment(F_MOVE_ABS, 0, 0, 0, 0, 0, 0);

    for (int ph = 0; ph < 7; ph++) begin
      drain();
      apb_write(REG_CUBIC_STEPS, cub_cfg[ph]);
      apb_write(REG_QUAD_STEPS, quad_cfg[ph]);
      if (ph == 6) calm = 1'b1;
      for (int i = 0; i < 48; i++) send_random();
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_path_segment_flattener_unit passed");
    end else begin
      $display("tb_path_segment_flattener_unit failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/psf_pkg.sv
rtl/psf_div.sv
rtl/psf_ctrl.sv
rtl/psf_datapath.sv
rtl/path_segment_flattener_unit.sv
tb/tb_path_segment_flattener_unit.sv
